FILE: design/vfca_pkg.sv
`default_nettype none
package vfca_pkg;

  // Store geometry
  localparam int unsigned VarCount = 1024;
  localparam int unsigned VarAw    = $clog2(VarCount);
  localparam int unsigned DataW    = 32;

  // Opcodes
  localparam logic [7:0] OpSet     = 8'h02;
  localparam logic [7:0] OpAdd     = 8'h03;
  localparam logic [7:0] OpSub     = 8'h04;
  localparam logic [7:0] OpMul     = 8'h05;
  localparam logic [7:0] OpDiv     = 8'h06;
  localparam logic [7:0] OpAnd     = 8'h07;
  localparam logic [7:0] OpOr      = 8'h08;
  localparam logic [7:0] OpNot     = 8'h09;
  localparam logic [7:0] OpGt      = 8'h0A;
  localparam logic [7:0] OpEq      = 8'h0B;
  localparam logic [7:0] OpLt      = 8'h0C;
  localparam logic [7:0] OpWaitGt  = 8'h0D;
  localparam logic [7:0] OpWaitEq  = 8'h0E;
  localparam logic [7:0] OpWaitLt  = 8'h0F;
  localparam logic [7:0] OpRead    = 8'h10;
  localparam logic [7:0] OpNe      = 8'h11;
  localparam logic [7:0] OpWaitNe  = 8'h12;
  localparam logic [7:0] OpMod     = 8'h13;
  localparam logic [7:0] OpSetCopy = 8'h14;

  // Operand types
  localparam logic [7:0] TypeImm = 8'hFF;
  localparam logic [7:0] TypeVar = 8'hFE;

  // Status codes
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic        [7:0]  operation;
    logic        [31:0] target_index;
    logic        [7:0]  operand_type;
    logic signed [31:0] operand_word;
  } req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] read_data;
    logic               read_valid;
  } rsp_t;

  typedef enum logic [1:0] {
    MdMul,
    MdDiv,
    MdMod
  } md_kind_e;

  typedef struct packed {
    logic             start;
    md_kind_e         kind;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } md_rsp_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StChk,
    StSrc,
    StTgt,
    StMd
  } state_e;

endpackage
`default_nettype wire

FILE: design/vfca_ram.sv
`default_nettype none
module vfca_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/vfca_muldiv.sv
`default_nettype none
module vfca_muldiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vfca_pkg::md_req_t req_i,
  output vfca_pkg::md_rsp_t      rsp_o
);
  import vfca_pkg::*;

  md_kind_e         kind_q;
  logic [DataW-1:0] acc_q, x_q, y_q;
  logic             neg_q;
  logic [4:0]       cnt_q;
  logic             run_q, done_q;

  logic [DataW:0]   add_a, add_b;
  logic [DataW+1:0] sum;
  logic             is_mul;
  logic [DataW-1:0] mag_a, mag_b;

  assign is_mul = (kind_q == MdMul);
  assign mag_a  = req_i.a[DataW-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign mag_b  = req_i.b[DataW-1] ? (~req_i.b + 1'b1) : req_i.b;

  // One shared adder: accumulate for multiply, trial subtract for divide and modulo
  always_comb begin
    if (is_mul) begin
      add_a = {1'b0, acc_q};
      add_b = {1'b0, y_q};
    end else begin
      add_a = {acc_q, x_q[DataW-1]};
      add_b = ~{1'b0, y_q};
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(DataW+1){1'b0}}, !is_mul};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      kind_q <= req_i.kind;
      acc_q  <= '0;
      if (req_i.kind == MdMul) begin
        x_q   <= req_i.a;
        y_q   <= req_i.b;
        neg_q <= 1'b0;
      end else begin
        x_q   <= mag_a;
        y_q   <= mag_b;
        neg_q <= (req_i.kind == MdDiv) ? (req_i.a[DataW-1] ^ req_i.b[DataW-1])
                                       : req_i.a[DataW-1];
      end
    end else if (run_q) begin
      if (is_mul) begin
        if (x_q[0]) begin
          acc_q <= sum[DataW-1:0];
        end
        x_q <= {1'b0, x_q[DataW-1:1]};
        y_q <= {y_q[DataW-2:0], 1'b0};
      end else if (sum[DataW+1]) begin
        acc_q <= sum[DataW-1:0];
        x_q   <= {x_q[DataW-2:0], 1'b1};
      end else begin
        acc_q <= {acc_q[DataW-2:0], x_q[DataW-1]};
        x_q   <= {x_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    case (kind_q)
      MdMul:   rsp_o.result = acc_q;
      MdDiv:   rsp_o.result = neg_q ? (~x_q + 1'b1) : x_q;
      MdMod:   rsp_o.result = neg_q ? (~acc_q + 1'b1) : acc_q;
      default: rsp_o.result = acc_q;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/variable_file_command_alu.sv
// Command ALU over a file of VarCount signed 32-bit variables. Raise start
// with a command on req_i; it is taken at the edge where start is high and
// busy is low. Exactly one response follows on rsp_o, shown for a single
// cycle while done_o is high; the receiver cannot stall it, so capture it on
// that cycle. Set, add, sub, logic, compare, wait, read, unknown opcodes and
// divide or modulo by zero pass through StChk and StTgt, with StSrc between
// them for a variable operand; an out-of-range target or source index is
// answered from StChk. Multiply, divide and modulo then go to StMd and run
// one bit per cycle through a shared 32-step shift/add/subtract unit, with
// a load step before and a write-back after. The variable store is a
// single-port-read RAM, so a variable operand needs its own read in StSrc
// before the target is fetched. After reset the block clears the store one
// word per cycle, holding busy high meanwhile. A new command may be accepted
// in the cycle its predecessor's response is shown.
`default_nettype none
module variable_file_command_alu (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire vfca_pkg::req_t req_i,
  output logic                busy,
  output logic                done_o,
  output vfca_pkg::rsp_t      rsp_o
);
  import vfca_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [DataW-1:0] num_q, num_d;
  logic [VarAw-1:0] clr_q, clr_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             ram_we;
  logic [VarAw-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  md_req_t          md_req;
  md_rsp_t          md_rsp;

  logic             tgt_bad, src_bad;
  logic [VarAw-1:0] tgt_addr, src_addr;
  logic [DataW-1:0] v, num;
  logic             lt_vn, lt_nv, eq_vn;

  vfca_ram #(
    .Width(DataW),
    .Depth(VarCount)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  vfca_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .rsp_o (md_rsp)
  );

  // Index checks on the held request
  assign tgt_bad  = (req_q.target_index >= 32'(VarCount));
  assign src_bad  = (req_q.operand_type == TypeVar) &&
                    ($unsigned(req_q.operand_word) >= 32'(VarCount));
  assign tgt_addr = req_q.target_index[VarAw-1:0];
  assign src_addr = req_q.operand_word[VarAw-1:0];

  // Compare terms for the target value against the operand
  assign v     = ram_rdata;
  assign num   = num_q;
  assign lt_vn = ($signed(v) < $signed(num));
  assign lt_nv = ($signed(num) < $signed(v));
  assign eq_vn = (v == num);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    num_d     = num_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = tgt_addr;
    ram_wdata = '0;
    ram_raddr = tgt_addr;
    md_req    = '{start: 1'b0, kind: MdMul, a: v, b: num};

    case (state_q)
      StClear: begin
        // Sweep the store to zero, one word per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == VarAw'(VarCount - 1)) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (start) begin
          req_d   = req_i;
          state_d = StChk;
        end
      end

      StChk: begin
        if (tgt_bad || src_bad) begin
          done_d  = 1'b1;
          rsp_d   = '{status: StatusFail, read_data: '0, read_valid: 1'b0};
          state_d = StIdle;
        end else if (req_q.operand_type == TypeVar) begin
          ram_raddr = src_addr;
          state_d   = StSrc;
        end else begin
          num_d   = (req_q.operand_type == TypeImm) ? req_q.operand_word
                                                    : {24'd0, req_q.operand_type};
          state_d = StTgt;
        end
      end

      StSrc: begin
        // Latch the source variable, then fetch the target
        num_d   = ram_rdata;
        state_d = StTgt;
      end

      StTgt: begin
        rsp_d   = '{status: StatusOk, read_data: '0, read_valid: 1'b0};
        done_d  = 1'b1;
        state_d = StIdle;
        case (req_q.operation)
          OpSet, OpSetCopy: begin
            ram_we    = 1'b1;
            ram_wdata = num;
          end
          OpAdd: begin
            ram_we    = 1'b1;
            ram_wdata = v + num;
          end
          OpSub: begin
            ram_we    = 1'b1;
            ram_wdata = v - num;
          end
          OpMul: begin
            md_req.start = 1'b1;
            md_req.kind  = MdMul;
            done_d       = 1'b0;
            state_d      = StMd;
          end
          OpDiv, OpMod: begin
            // Division or modulo by zero leaves the target alone
            if (num != '0) begin
              md_req.start = 1'b1;
              md_req.kind  = (req_q.operation == OpDiv) ? MdDiv : MdMod;
              done_d       = 1'b0;
              state_d      = StMd;
            end
          end
          OpAnd: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, (v != '0) && (num != '0)};
          end
          OpOr: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, (v != '0) || (num != '0)};
          end
          OpNot: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, v == '0};
          end
          OpGt: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, lt_nv};
          end
          OpEq: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, eq_vn};
          end
          OpLt: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, lt_vn};
          end
          OpNe: begin
            ram_we    = 1'b1;
            ram_wdata = {31'd0, !eq_vn};
          end
          OpWaitGt: rsp_d.status = lt_nv ? StatusOk : StatusFail;
          OpWaitEq: rsp_d.status = eq_vn ? StatusOk : StatusFail;
          OpWaitLt: rsp_d.status = lt_vn ? StatusOk : StatusFail;
          OpWaitNe: rsp_d.status = eq_vn ? StatusFail : StatusOk;
          OpRead: begin
            rsp_d.read_data  = v;
            rsp_d.read_valid = 1'b1;
          end
          default: ;
        endcase
      end

      StMd: begin
        // Hold until the shared unit finishes, then write back
        if (md_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = md_rsp.result;
          rsp_d     = '{status: StatusOk, read_data: '0, read_valid: 1'b0};
          done_d    = 1'b1;
          state_d   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    num_q <= num_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A read response never reports failure
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.read_valid |-> rsp_o.status == StatusOk)
    else $error("read response carries failure status");

  // The shared unit only finishes while the sequencer waits for it
  a_md_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> state_q == StMd)
    else $error("muldiv finished outside its wait state");

  // An accepted request enters the sequence, with busy high and no response yet
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("request accepted without entering the sequence");

  // The store is never written while idle
  a_no_idle_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != StIdle)
    else $error("store written while idle");

endmodule
`default_nettype wire
